@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is high.
`define GFBA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property that is also checked during reset.
`define GFBA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/gfba_pkg.sv @@
// Shared sizes, beat types and codes of the grouped free block allocator.
// No dependencies; imported by the top level and the checker.
package gfba_pkg;

   localparam int GROUP_SIZE = 100;
   localparam int NUM_GROUPS = 64;
   localparam int BLOCK_BITS = 16;

   localparam int SLOT_DEPTH = NUM_GROUPS * GROUP_SIZE;
   localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
   localparam int BASE_W     = $clog2(SLOT_DEPTH + 1);
   localparam int GROUP_AW   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int DEPTH_W    = $clog2(NUM_GROUPS + 1);
   localparam int FILL_W     = $clog2(GROUP_SIZE + 1);

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      KIND_FREE     = 1'b0,
      KIND_ALLOCATE = 1'b1
   } kind_type;

   // Where the granted block of the pending beat comes from.
   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_SLOT = 2'd1,
      SRC_OWN  = 2'd2
   } grant_src_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] block_in;
   } req_type;

   typedef struct packed {
      logic [15:0] granted_block;
      logic [1:0]  status;
      logic [6:0]  groups_in_use;
   } rsp_type;

endpackage

@@ rtl/core/grouped_free_block_allocator.sv @@
// Grouped free block allocator: stack of groups in two synchronous memories.
// Depends on gfba_pkg.
//
//   channel  | ports                      | direction | flow
//   ---------+----------------------------+-----------+------------------------
//   request  | start, busy, req_data      | in        | beat when start & !busy
//   response | rsp_valid, rsp_data        | out       | one-cycle strobe
//
// For each beat, the accept cycle updates the head registers and drives one
// access to the slot memory or the own-block memory; the next cycle presents
// the registered read data as the response, with busy high.
// Synchronous reset empties the stack (depth zero); memory contents are kept.
// The response cannot be stalled; a new beat is taken once it has gone.
module grouped_free_block_allocator import gfba_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic [BLOCK_BITS-1:0] slot_mem [SLOT_DEPTH];
   logic [BLOCK_BITS-1:0] own_mem  [NUM_GROUPS];

   logic [DEPTH_W-1:0]    depth_ff, depth_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;      // fill of the head group
   logic [BASE_W-1:0]     next_base_ff, next_base_in;
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff, rsp_status_in;
   grant_src_type         rsp_src_ff, rsp_src_in;
   logic [BLOCK_BITS-1:0] slot_rdata_ff, own_rdata_ff;

   logic                  accept;
   logic [BLOCK_BITS-1:0] blk;
   logic [BASE_W-1:0]     head_base;
   logic [SLOT_AW-1:0]    slot_addr;
   logic                  slot_we;
   logic [GROUP_AW-1:0]   own_addr;
   logic                  own_we;

   assign accept    = start && !busy;
   assign blk       = BLOCK_BITS'(req_data.block_in);
   assign head_base = next_base_ff - BASE_W'(GROUP_SIZE);

   always_comb begin
      depth_in      = depth_ff;
      fill_in       = fill_ff;
      next_base_in  = next_base_ff;
      rsp_status_in = STATUS_OK;
      rsp_src_in    = SRC_NONE;
      slot_addr     = SLOT_AW'(head_base + BASE_W'(fill_ff));
      slot_we       = 1'b0;
      own_addr      = GROUP_AW'(depth_ff - DEPTH_W'(1));
      own_we        = 1'b0;
      if (accept) begin
         if (req_data.kind == KIND_FREE) begin
            if (depth_ff != '0 && fill_ff < FILL_W'(GROUP_SIZE)) begin
               slot_we = 1'b1;
               fill_in = fill_ff + FILL_W'(1);
            end else if (depth_ff >= DEPTH_W'(NUM_GROUPS)) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               // freed block opens a new head group as its own number
               own_addr     = GROUP_AW'(depth_ff);
               own_we       = 1'b1;
               depth_in     = depth_ff + DEPTH_W'(1);
               fill_in      = FILL_W'(1);
               next_base_in = next_base_ff + BASE_W'(GROUP_SIZE);
            end
         end else begin
            if (depth_ff == '0) begin
               rsp_status_in = STATUS_EMPTY;
            end else if (fill_ff > FILL_W'(1)) begin
               slot_addr  = SLOT_AW'(head_base + BASE_W'(fill_ff) - BASE_W'(1));
               fill_in    = fill_ff - FILL_W'(1);
               rsp_src_in = SRC_SLOT;
            end else begin
               // group retires; groups below the head are always full
               rsp_src_in   = SRC_OWN;
               depth_in     = depth_ff - DEPTH_W'(1);
               fill_in      = FILL_W'(GROUP_SIZE);
               next_base_in = head_base;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_addr] <= blk;
      end
      slot_rdata_ff <= slot_mem[slot_addr];
   end

   always_ff @(posedge clock) begin
      if (own_we) begin
         own_mem[own_addr] <= blk;
      end
      own_rdata_ff <= own_mem[own_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= '0;
         fill_ff       <= '0;
         next_base_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= STATUS_OK;
         rsp_src_ff    <= SRC_NONE;
      end else begin
         depth_ff      <= depth_in;
         fill_ff       <= fill_in;
         next_base_ff  <= next_base_in;
         rsp_valid_ff  <= accept;
         rsp_status_ff <= rsp_status_in;
         rsp_src_ff    <= rsp_src_in;
      end
   end

   assign busy      = rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.status        = rsp_status_ff;
      rsp_data.groups_in_use = 7'(depth_ff);
      case (rsp_src_ff)
         SRC_SLOT: rsp_data.granted_block = 16'(slot_rdata_ff);
         SRC_OWN:  rsp_data.granted_block = 16'(own_rdata_ff);
         default:  rsp_data.granted_block = '0;
      endcase
   end

endmodule

@@ rtl/core/gfba_checker.sv @@
// Port-level checks of the grouped free block allocator, bound to the top.
// Depends on gfba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gfba_checker import gfba_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   `GFBA_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "response after reset")
   `GFBA_ASSERT(a_beat_answered, clock, reset,
      (start && !busy) |=> rsp_valid, "accepted beat not answered")
   `GFBA_ASSERT(a_single_strobe, clock, reset,
      rsp_valid |=> !rsp_valid, "response held two cycles")
   `GFBA_ASSERT(a_fail_no_grant, clock, reset,
      (rsp_valid && rsp_data.status != STATUS_OK) |-> (rsp_data.granted_block == '0),
      "failed beat grants a block")
   `GFBA_ASSERT(a_empty_no_groups, clock, reset,
      (rsp_valid && rsp_data.status == STATUS_EMPTY) |-> (rsp_data.groups_in_use == '0),
      "empty status with groups left")

endmodule

bind grouped_free_block_allocator gfba_checker u_gfba_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

@@ tb/grouped_free_block_allocator_tb.sv @@
// Self-checking testbench for the grouped free block allocator: directed beats and
// random free/allocate traffic, all checked against a shadow stack.
// Depends on gfba_pkg and grouped_free_block_allocator.
`timescale 1ns / 1ps

module grouped_free_block_allocator_tb;
   import gfba_pkg::*;

   localparam int RANDOM_BEATS = 620;
   localparam int SETTLE_CYCLES = 10;
   localparam logic [15:0] BLK_MASK = 16'((64'd1 << BLOCK_BITS) - 1);

   typedef struct {
      req_type     beat;
      int unsigned gap;
      bit          drain;
   } pending_beat_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   pending_beat_type beats_to_send[$];
   rsp_type          grants_due[$];
   int unsigned      gap_left = 0;
   int               in_flight = 0;
   int               mismatches = 0;
   bit               quiet = 1'b0;

   // shadow copy of the group stack
   logic [15:0]         shadow_slots[SLOT_DEPTH];
   logic [15:0]         shadow_own[NUM_GROUPS];
   logic [FILL_W-1:0]   shadow_fill[NUM_GROUPS];
   logic [DEPTH_W-1:0]  shadow_depth = '0;

   grouped_free_block_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type allocator_step(req_type beat);
      rsp_type     r;
      int          top;
      logic [15:0] blk;
      r = '0;
      r.status = STATUS_OK;
      blk = beat.block_in & BLK_MASK;
      if (beat.kind == KIND_FREE) begin
         if (shadow_depth > 0 && shadow_fill[int'(shadow_depth) - 1] < GROUP_SIZE) begin
            top = int'(shadow_depth) - 1;
            shadow_slots[top * GROUP_SIZE + int'(shadow_fill[top])] = blk;
            shadow_fill[top] = shadow_fill[top] + FILL_W'(1);
         end else if (shadow_depth >= NUM_GROUPS) begin
            r.status = STATUS_FULL;
         end else begin
            // freed block opens a new head group as its own number
            shadow_own[shadow_depth] = blk;
            shadow_fill[shadow_depth] = FILL_W'(1);
            shadow_depth = shadow_depth + DEPTH_W'(1);
         end
      end else if (shadow_depth == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         top = int'(shadow_depth) - 1;
         if (shadow_fill[top] > 1) begin
            shadow_fill[top] = shadow_fill[top] - FILL_W'(1);
            r.granted_block = shadow_slots[top * GROUP_SIZE + int'(shadow_fill[top])];
         end else begin
            // last block of a group is its own number; group retires
            shadow_fill[top] = '0;
            r.granted_block = shadow_own[top];
            shadow_depth = shadow_depth - DEPTH_W'(1);
         end
      end
      r.groups_in_use = 7'(shadow_depth);
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_block();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   task automatic queue_beat(kind_type k, logic [15:0] blk, bit drain = 1'b0);
      pending_beat_type p;
      p.beat.kind = k;
      p.beat.block_in = blk;
      p.gap = pick_gap();
      p.drain = drain;
      beats_to_send.push_back(p);
   endtask

   task automatic report_mismatch(string what);
      if (mismatches < 40)
         $display("%0t: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // driver
   always @(posedge clock) begin
      pending_beat_type nxt;
      bit               go;
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         gap_left = 0;
         in_flight = 0;
      end else begin
         if (rsp_valid && in_flight > 0)
            in_flight--;
         if (start && !busy)
            in_flight++;
         if (!start || !busy) begin
            go = 1'b0;
            if (beats_to_send.size() > 0) begin
               if (gap_left > 0)
                  gap_left--;
               else if (!beats_to_send[0].drain || in_flight == 0)
                  go = 1'b1;
            end
            if (go) begin
               nxt = beats_to_send.pop_front();
               start <= 1'b1;
               req_data <= nxt.beat;
               gap_left = nxt.gap;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: check responses, then predict the beat taken at this edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (grants_due.size() == 0) begin
               report_mismatch("response with no beat outstanding");
            end else begin
               want = grants_due.pop_front();
               if (rsp_data.granted_block !== want.granted_block)
                  report_mismatch($sformatf("granted_block %h, expected %h",
                                            rsp_data.granted_block, want.granted_block));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.groups_in_use !== want.groups_in_use)
                  report_mismatch($sformatf("groups_in_use %0d, expected %0d",
                                            rsp_data.groups_in_use, want.groups_in_use));
            end
         end
         if (start && !busy)
            grants_due.push_back(allocator_step(req_data));
      end
   end

   initial begin
      int          sent;
      int          chunk;
      int unsigned free_pct;
      int unsigned pcts[5];

      pcts = '{10, 35, 50, 65, 90};

      // directed: empty, zero and all-ones blocks, own-number hand-out
      queue_beat(KIND_ALLOCATE, 16'hFFFF);
      queue_beat(KIND_FREE, 16'h0000);
      queue_beat(KIND_FREE, 16'hFFFF);
      queue_beat(KIND_FREE, 16'h8000);
      queue_beat(KIND_ALLOCATE, 16'h0000);
      queue_beat(KIND_ALLOCATE, 16'h1234);
      queue_beat(KIND_ALLOCATE, 16'hFFFF);
      queue_beat(KIND_ALLOCATE, 16'h0000);
      queue_beat(KIND_FREE, 16'h5555, 1'b1);
      queue_beat(KIND_FREE, 16'hAAAA);
      queue_beat(KIND_ALLOCATE, 16'h0001);
      queue_beat(KIND_ALLOCATE, 16'h7FFF);
      queue_beat(KIND_ALLOCATE, 16'hAAAA);

      // random: chunks with a free/allocate bias so the depth wanders
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         chunk = $urandom_range(40, 80);
         if (chunk > RANDOM_BEATS - sent)
            chunk = RANDOM_BEATS - sent;
         free_pct = pcts[$urandom_range(0, 4)];
         quiet = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < chunk; i++) begin
            queue_beat(($urandom_range(0, 99) < free_pct) ? KIND_FREE : KIND_ALLOCATE,
                       pick_block(), i == 0 && $urandom_range(0, 2) == 0);
         end
         sent += chunk;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (beats_to_send.size() > 0 || start)
         @(negedge clock);
      while (grants_due.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("grouped_free_block_allocator_tb OK");
      else
         $display("grouped_free_block_allocator_tb NOT OK");
      $finish;
   end

   initial begin
      #2000000;
      $display("%0t: timeout", $time);
      $display("grouped_free_block_allocator_tb NOT OK");
      $finish;
   end

endmodule
